// File: hw/rtl/pixel_replication_upscaler_top_defines.svh
// Assertion macros shared by the upscaler RTL.
`ifndef PIXEL_REPLICATION_UPSCALER_TOP_DEFINES_SVH
`define PIXEL_REPLICATION_UPSCALER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PRU_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PRU_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/pru_pkg.sv
// Types and constants of the pixel replication upscaler.
package pru_pkg;

    // Sizes
    localparam int MAX_WIDTH = 2048;
    localparam int MAX_SCALE = 100;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WIDTH_W   = 12;
    localparam int SCALE_W   = 7;
    localparam int PIX_W     = 24;
    localparam int PAD_W     = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 12;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SCALE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 1'd1;

    // Request modes
    localparam logic MODE_PIXEL  = 1'b0;
    localparam logic MODE_REPLAY = 1'b1;

    typedef struct packed {
        logic             mode;
        logic [PIX_W-1:0] pixel_in;
    } in_item_t;

    typedef struct packed {
        logic [PIX_W-1:0]   pixel_out;
        logic [SCALE_W-1:0] repeat_count;
        logic [SCALE_W-1:0] copy_index;
        logic               row_end;
        logic [PAD_W-1:0]   pad_bytes;
        logic               error;
    } out_item_t;

    // Line buffer access for one cycle
    typedef struct packed {
        logic             we;
        logic             re;
        logic [COL_W-1:0] addr;
    } line_req_t;

endpackage

// File: hw/rtl/pixel_replication_upscaler_top.sv
// Nearest-neighbor integer upscaler: control, line buffer and output stages.
//
//  channel   dir   handshake              payload
//  src       in    src_valid/src_stall    src_item  (mode, pixel_in)
//  dst       out   dst_valid/dst_stall    dst_item  (pixel_out .. error)
//  cfg       in    cfg_we                 cfg_index, cfg_data
//
// One request per clock while the output is not stalled; each result goes
// through the read stage (line buffer read), then the output register.
// The single-port line buffer is touched at most once per request: a pixel
// writes it, a replay reads it; consecutive requests never collide on an entry.
// Reset sets scale and width to one and clears the other control state;
// buffer contents are undefined until written. A stalled output holds; input
// keeps taking requests until read stage and output register are both full.
`include "pixel_replication_upscaler_top_defines.svh"

module pixel_replication_upscaler_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              src_valid,
    output logic                              src_stall,
    input  pru_pkg::in_item_t                 src_item,
    output logic                              dst_valid,
    input  logic                              dst_stall,
    output pru_pkg::out_item_t                dst_item,
    input  logic                              cfg_we,
    input  logic [pru_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pru_pkg::CFG_DAT_W-1:0]     cfg_data
);

    // Configuration registers
    logic [pru_pkg::SCALE_W-1:0] scale_reg;
    logic [pru_pkg::WIDTH_W-1:0] width_reg;

    // Row control
    logic [pru_pkg::COL_W-1:0]   wcol_reg, wcol_next;
    logic [pru_pkg::COL_W-1:0]   rcol_reg, rcol_next;
    logic [pru_pkg::SCALE_W-1:0] copies_owed_reg, copies_owed_next;
    logic [pru_pkg::SCALE_W-1:0] cur_copy_reg, cur_copy_next;

    // Read stage
    logic                        s1_valid_reg, s1_valid_next;
    logic                        s1_use_mem_reg;
    logic [pru_pkg::PIX_W-1:0]   s1_pix_reg;
    logic [pru_pkg::SCALE_W-1:0] s1_rep_reg;
    logic [pru_pkg::SCALE_W-1:0] s1_copy_reg;
    logic                        s1_end_reg;
    logic [pru_pkg::PAD_W-1:0]   s1_pad_reg;
    logic                        s1_err_reg;

    // Output stage
    logic                        out_valid_reg, out_valid_next;
    pru_pkg::out_item_t          out_item_reg;

    logic                        src_accept;
    logic                        s1_move;
    logic                        is_pixel;
    logic                        owed;
    logic                        req_err;
    logic                        row_done;
    logic [pru_pkg::SCALE_W-1:0] eff_scale;
    logic [pru_pkg::WIDTH_W-1:0] eff_width;
    logic [pru_pkg::WIDTH_W-1:0] col_plus1;
    logic [3:0]                  pad_prod;
    logic [pru_pkg::PAD_W-1:0]   pad_val;
    logic [pru_pkg::SCALE_W-1:0] copy_val;
    logic [pru_pkg::SCALE_W-1:0] owed_less1;
    logic [pru_pkg::SCALE_W-1:0] scale_less1;
    pru_pkg::line_req_t          ram_req;
    logic [pru_pkg::PIX_W-1:0]   ram_rdata;

    // Handshake
    assign s1_move    = s1_valid_reg && (!out_valid_reg || !dst_stall);
    assign src_stall  = s1_valid_reg && !s1_move;
    assign src_accept = src_valid && !src_stall;

    // Effective scale and width, clamped to the supported range
    always_comb
    begin
        if (scale_reg == '0)
            eff_scale = pru_pkg::SCALE_W'(1);
        else if (scale_reg > pru_pkg::SCALE_W'(pru_pkg::MAX_SCALE))
            eff_scale = pru_pkg::SCALE_W'(pru_pkg::MAX_SCALE);
        else
            eff_scale = scale_reg;

        if (width_reg == '0)
            eff_width = pru_pkg::WIDTH_W'(1);
        else if (width_reg > pru_pkg::WIDTH_W'(pru_pkg::MAX_WIDTH))
            eff_width = pru_pkg::WIDTH_W'(pru_pkg::MAX_WIDTH);
        else
            eff_width = width_reg;
    end

    // Pad is -(3*w*s) mod 4, which equals (w*s) mod 4
    assign pad_prod = {2'b00, eff_width[1:0]} * {2'b00, eff_scale[1:0]};
    assign pad_val  = pad_prod[1:0];

    // Request decode
    assign is_pixel    = (src_item.mode == pru_pkg::MODE_PIXEL);
    assign owed        = (copies_owed_reg != '0);
    assign req_err     = is_pixel ? owed : !owed;
    assign col_plus1   = {1'b0, (is_pixel ? wcol_reg : rcol_reg)} + pru_pkg::WIDTH_W'(1);
    assign row_done    = (col_plus1 >= eff_width);
    assign copy_val    = is_pixel ? '0 : cur_copy_reg;
    assign owed_less1  = copies_owed_reg - pru_pkg::SCALE_W'(1);
    assign scale_less1 = eff_scale - pru_pkg::SCALE_W'(1);

    // Line buffer access
    always_comb
    begin
        ram_req.we   = src_accept && !req_err && is_pixel;
        ram_req.re   = src_accept && !req_err && !is_pixel;
        ram_req.addr = is_pixel ? wcol_reg : rcol_reg;
    end

    pru_line_ram u_line_ram (
        .clk   (clk),
        .req   (ram_req),
        .wdata (src_item.pixel_in),
        .rdata (ram_rdata)
    );

    // Row and copy bookkeeping
    always_comb
    begin
        wcol_next        = wcol_reg;
        rcol_next        = rcol_reg;
        copies_owed_next = copies_owed_reg;
        cur_copy_next    = cur_copy_reg;
        if (src_accept && !req_err)
        begin
            if (is_pixel)
            begin
                if (row_done)
                begin
                    wcol_next        = '0;
                    rcol_next        = '0;
                    copies_owed_next = scale_less1;
                    cur_copy_next    = (scale_less1 != '0) ? pru_pkg::SCALE_W'(1) : '0;
                end
                else
                begin
                    wcol_next = wcol_reg + pru_pkg::COL_W'(1);
                end
            end
            else
            begin
                if (row_done)
                begin
                    rcol_next        = '0;
                    copies_owed_next = owed_less1;
                    cur_copy_next    = (owed_less1 != '0) ?
                                       (cur_copy_reg + pru_pkg::SCALE_W'(1)) : '0;
                end
                else
                begin
                    rcol_next = rcol_reg + pru_pkg::COL_W'(1);
                end
            end
        end
    end

    // Stage valids
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (src_accept)
            s1_valid_next = 1'b1;
        else if (s1_move)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (s1_move)
            out_valid_next = 1'b1;
        else if (!dst_stall)
            out_valid_next = 1'b0;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg       <= pru_pkg::SCALE_W'(1);
            width_reg       <= pru_pkg::WIDTH_W'(1);
            wcol_reg        <= '0;
            rcol_reg        <= '0;
            copies_owed_reg <= '0;
            cur_copy_reg    <= '0;
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == pru_pkg::REG_SCALE)
                scale_reg <= cfg_data[pru_pkg::SCALE_W-1:0];
            if (cfg_we && cfg_index == pru_pkg::REG_WIDTH)
                width_reg <= cfg_data[pru_pkg::WIDTH_W-1:0];
            wcol_reg        <= wcol_next;
            rcol_reg        <= rcol_next;
            copies_owed_reg <= copies_owed_next;
            cur_copy_reg    <= cur_copy_next;
            s1_valid_reg    <= s1_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Read stage payload
    always_ff @(posedge clk)
    begin
        if (src_accept)
        begin
            s1_use_mem_reg <= !req_err && !is_pixel;
            s1_pix_reg     <= req_err ? '0 : src_item.pixel_in;
            s1_rep_reg     <= req_err ? '0 : eff_scale;
            s1_copy_reg    <= req_err ? '0 : copy_val;
            s1_end_reg     <= !req_err && row_done;
            s1_pad_reg     <= (!req_err && row_done) ? pad_val : '0;
            s1_err_reg     <= req_err;
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_item_reg.pixel_out    <= s1_use_mem_reg ? ram_rdata : s1_pix_reg;
            out_item_reg.repeat_count <= s1_rep_reg;
            out_item_reg.copy_index   <= s1_copy_reg;
            out_item_reg.row_end      <= s1_end_reg;
            out_item_reg.pad_bytes    <= s1_pad_reg;
            out_item_reg.error        <= s1_err_reg;
        end
    end

    assign dst_valid = out_valid_reg;
    assign dst_item  = out_item_reg;

    // Checks
    `PRU_ASSERT_IMP(a_owed_has_copy, copies_owed_reg != '0, cur_copy_reg != '0, "owed copies without copy number")
    `PRU_ASSERT_IMP(a_idle_no_copy, copies_owed_reg == '0, cur_copy_reg == '0, "copy number with nothing owed")
    `PRU_ASSERT_IMP(a_write_mid_row, wcol_reg != '0, copies_owed_reg == '0, "source row open while copies owed")
    `PRU_ASSERT_IMP(a_replay_mid_row, rcol_reg != '0, copies_owed_reg != '0, "replay position with nothing owed")
    `PRU_ASSERT_NXT(a_bad_replay_err, src_accept && !is_pixel && copies_owed_reg == '0, s1_err_reg, "replay with nothing owed not flagged")

endmodule

// File: hw/rtl/pru_line_ram.sv
// Single-port line buffer, one access per cycle, registered read data.
module pru_line_ram (
    input  logic                          clk,
    input  pru_pkg::line_req_t            req,
    input  logic [pru_pkg::PIX_W-1:0]     wdata,
    output logic [pru_pkg::PIX_W-1:0]     rdata
);

    logic [pru_pkg::PIX_W-1:0] mem [pru_pkg::MAX_WIDTH];
    logic [pru_pkg::PIX_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr] <= wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: tb/tb.sv
// Self-checking testbench for the nearest-neighbor pixel replication upscaler.
`timescale 1ns / 100ps

module tb;

    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 300;
    localparam int SEG_ITEMS   = 170;
    localparam int NOISE_PCT   = 10;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          src_valid = 1'b0;
    logic                          src_stall;
    pru_pkg::in_item_t             src_item = '0;
    logic                          dst_valid;
    logic                          dst_stall = 1'b0;
    pru_pkg::out_item_t            dst_item;
    logic                          cfg_we = 1'b0;
    logic [pru_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [pru_pkg::CFG_DAT_W-1:0] cfg_data = '0;

    // Request feed, expected results and traffic shaping
    pru_pkg::in_item_t  pending_requests[$];
    pru_pkg::out_item_t expected_pixels[$];
    int        sender_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        hold_requests = 0;
    int        fail_count = 0;
    int        cycle_count = 0;

    // Predictor copy of the upscaler state
    logic [pru_pkg::PIX_W-1:0]   line_mem [0:pru_pkg::MAX_WIDTH-1];
    logic [pru_pkg::COL_W-1:0]   pr_wcol = '0;
    logic [pru_pkg::COL_W-1:0]   pr_rcol = '0;
    logic [pru_pkg::SCALE_W-1:0] pr_owed = '0;
    logic [pru_pkg::SCALE_W-1:0] pr_copy = '0;
    logic [pru_pkg::SCALE_W-1:0] pr_scale_reg = 7'd1;
    logic [pru_pkg::WIDTH_W-1:0] pr_width_reg = 12'd1;
    int                          line_fill = 0;  // columns written at least once

    // Row planner: requests still due in the current row and its copies
    int pix_left = 1;
    int rep_left = 0;

    pixel_replication_upscaler_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_item  (src_item),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_item  (dst_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned active_scale();
        if (pr_scale_reg == 0)
            return 1;
        if (pr_scale_reg > pru_pkg::MAX_SCALE)
            return pru_pkg::MAX_SCALE;
        return 32'(pr_scale_reg);
    endfunction

    function automatic int unsigned active_width();
        if (pr_width_reg == 0)
            return 1;
        if (pr_width_reg > pru_pkg::MAX_WIDTH)
            return pru_pkg::MAX_WIDTH;
        return 32'(pr_width_reg);
    endfunction

    // Expected result of one accepted request; advances the predictor state
    function automatic pru_pkg::out_item_t upscale_predict(pru_pkg::in_item_t req);
        pru_pkg::out_item_t res;
        int unsigned        s;
        int unsigned        w;
        logic               done;
        res = '0;
        s = active_scale();
        w = active_width();
        if (req.mode == pru_pkg::MODE_PIXEL)
        begin
            if (pr_owed != 0)
            begin
                res.error = 1'b1;
                return res;
            end
            line_mem[pr_wcol] = req.pixel_in;
            if (pr_wcol + 1 > line_fill)
                line_fill = pr_wcol + 1;
            res.pixel_out = req.pixel_in;
            res.copy_index = '0;
            done = (pr_wcol + 1 >= w);
            if (done)
            begin
                pr_wcol = '0;
                pr_rcol = '0;
                pr_owed = pru_pkg::SCALE_W'(s - 1);
                pr_copy = (pr_owed != 0) ? 7'd1 : 7'd0;
            end
            else
                pr_wcol = pr_wcol + 1'b1;
        end
        else
        begin
            if (pr_owed == 0)
            begin
                res.error = 1'b1;
                return res;
            end
            res.pixel_out = line_mem[pr_rcol];
            res.copy_index = pr_copy;
            done = (pr_rcol + 1 >= w);
            if (done)
            begin
                pr_rcol = '0;
                pr_owed = pr_owed - 1'b1;
                pr_copy = (pr_owed != 0) ? pr_copy + 1'b1 : 7'd0;
            end
            else
                pr_rcol = pr_rcol + 1'b1;
        end
        res.repeat_count = pru_pkg::SCALE_W'(s);
        res.row_end = done;
        res.pad_bytes = done ? pru_pkg::PAD_W'((4 - (w * s * 3) % 4) % 4) : '0;
        return res;
    endfunction

    // Re-derive the row plan from the predictor; only called while idle
    function automatic void replan();
        int w;
        w = active_width();
        if (pr_owed != 0)
        begin
            rep_left = ((pr_rcol + 1 >= w) ? 1 : w - pr_rcol) + (pr_owed - 1) * w;
            pix_left = w;
        end
        else
        begin
            rep_left = 0;
            pix_left = (pr_wcol + 1 >= w) ? 1 : w - pr_wcol;
        end
    endfunction

    // Next request of a well-formed stream, or an out-of-order one by chance
    function automatic pru_pkg::in_item_t plan_item(int noise_pct);
        pru_pkg::in_item_t req;
        req.pixel_in = pru_pkg::PIX_W'($urandom());
        if ($urandom_range(99) < noise_pct)
            req.mode = (rep_left > 0) ? pru_pkg::MODE_PIXEL : pru_pkg::MODE_REPLAY;
        else if (rep_left > 0)
        begin
            req.mode = pru_pkg::MODE_REPLAY;
            rep_left--;
        end
        else
        begin
            req.mode = pru_pkg::MODE_PIXEL;
            pix_left--;
            if (pix_left == 0)
            begin
                rep_left = (active_scale() - 1) * active_width();
                pix_left = active_width();
            end
        end
        return req;
    endfunction

    task automatic push_req(input logic mode, input logic [pru_pkg::PIX_W-1:0] pix);
        pru_pkg::in_item_t req;
        req.mode = mode;
        req.pixel_in = pix;
        pending_requests.push_back(req);
    endtask

    task automatic send_planned(input int count, input int noise_pct);
        repeat (count)
            pending_requests.push_back(plan_item(noise_pct));
    endtask

    // Returns at a falling edge once every request is in and answered
    task automatic wait_idle();
        @(negedge clk);
        while (pending_requests.size() != 0 || src_valid || expected_pixels.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [pru_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pru_pkg::CFG_DAT_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(input logic [pru_pkg::SCALE_W-1:0] scale,
                              input logic [pru_pkg::WIDTH_W-1:0] width);
        write_reg(pru_pkg::REG_SCALE, pru_pkg::CFG_DAT_W'(scale));
        write_reg(pru_pkg::REG_WIDTH, width);
        @(negedge clk);
        replan();
    endtask

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, fname, want, got);
            fail_count++;
        end
    endtask

    // Request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_valid <= 1'b0;
            src_item <= '0;
        end
        else if (!src_valid || !src_stall)
        begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                src_item <= pending_requests.pop_front();
                src_valid <= 1'b1;
            end
            else
                src_valid <= 1'b0;
        end
    end

    // Result receiver: random stalls, plus long hold-offs on demand
    always @(posedge clk or negedge rst_n)
    begin
        int holds_served;
        int hold_left;
        if (!rst_n)
        begin
            dst_stall <= 1'b0;
            holds_served = 0;
            hold_left = 0;
        end
        else if (hold_left > 0)
        begin
            dst_stall <= 1'b1;
            hold_left--;
        end
        else if (holds_served != hold_requests)
        begin
            holds_served++;
            hold_left = HOLD_CYCLES - 1;
            dst_stall <= 1'b1;
        end
        else
            dst_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Monitor: register writes, accepted requests, accepted results
    always @(posedge clk)
    begin
        pru_pkg::out_item_t want;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    pru_pkg::REG_SCALE: pr_scale_reg = cfg_data[pru_pkg::SCALE_W-1:0];
                    pru_pkg::REG_WIDTH: pr_width_reg = cfg_data[pru_pkg::WIDTH_W-1:0];
                    default: ;
                endcase
            end
            if (src_valid && !src_stall)
                expected_pixels.push_back(upscale_predict(src_item));
            if (dst_valid && !dst_stall)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none actual %h", $time, dst_item);
                    fail_count++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    check_field("pixel_out", 32'(want.pixel_out),
                                32'(dst_item.pixel_out));
                    check_field("repeat_count", 32'(want.repeat_count),
                                32'(dst_item.repeat_count));
                    check_field("copy_index", 32'(want.copy_index),
                                32'(dst_item.copy_index));
                    check_field("row_end", 32'(want.row_end),
                                32'(dst_item.row_end));
                    check_field("pad_bytes", 32'(want.pad_bytes),
                                32'(dst_item.pad_bytes));
                    check_field("error", 32'(want.error),
                                32'(dst_item.error));
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Stimulus sequence
    initial
    begin
        logic [pru_pkg::SCALE_W-1:0] scale;
        logic [pru_pkg::WIDTH_W-1:0] width;
        int                          eff_w;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: stray replay, then single-pixel rows
        push_req(pru_pkg::MODE_REPLAY, 24'hFFFFFF);
        push_req(pru_pkg::MODE_PIXEL, 24'h000000);
        push_req(pru_pkg::MODE_PIXEL, 24'hFFFFFF);
        wait_idle();

        // Zero registers act as one
        set_config(7'd0, 12'd0);
        push_req(pru_pkg::MODE_PIXEL, 24'hA5A5A5);
        wait_idle();

        // Row of two, pixel while copies owed, two copies, replay with none owed
        set_config(7'd3, 12'd2);
        push_req(pru_pkg::MODE_PIXEL, 24'h123456);
        push_req(pru_pkg::MODE_PIXEL, 24'hFEDCBA);
        push_req(pru_pkg::MODE_PIXEL, 24'h5A5A5A);
        repeat (4)
            push_req(pru_pkg::MODE_REPLAY, 24'h000000);
        push_req(pru_pkg::MODE_REPLAY, 24'h0F0F0F);
        wait_idle();

        // Width shrinks mid-row, scale changes mid-copy
        set_config(7'd2, 12'd5);
        push_req(pru_pkg::MODE_PIXEL, 24'h010203);
        push_req(pru_pkg::MODE_PIXEL, 24'h808080);
        push_req(pru_pkg::MODE_PIXEL, 24'h7F7F7F);
        wait_idle();
        set_config(7'd2, 12'd2);
        push_req(pru_pkg::MODE_PIXEL, 24'hC0FFEE);
        push_req(pru_pkg::MODE_REPLAY, 24'h000000);
        wait_idle();
        set_config(7'd4, 12'd2);
        push_req(pru_pkg::MODE_REPLAY, 24'hFFFFFF);
        push_req(pru_pkg::MODE_REPLAY, 24'h000000);
        wait_idle();

        // Scale beyond range clips to the maximum: one pixel, 99 copies
        set_config(7'h7F, 12'd1);
        send_planned(pru_pkg::MAX_SCALE, 0);
        wait_idle();

        // Width beyond range: a long open row, closed by the next narrower width
        set_config(7'd1, 12'hFFF);
        send_planned(pru_pkg::MAX_WIDTH / 8, 0);
        wait_idle();

        // Random segments, config changes land wherever the last one stopped
        for (int seg = 0; seg < 8; seg++)
        begin
            case (seg % 4)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 61; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 61; end
                default: begin sender_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            scale = ($urandom_range(9) == 0) ? pru_pkg::SCALE_W'($urandom_range(0, 127))
                                             : pru_pkg::SCALE_W'($urandom_range(1, 5));
            width = ($urandom_range(9) == 0) ? pru_pkg::WIDTH_W'($urandom_range(13, 80))
                                             : pru_pkg::WIDTH_W'($urandom_range(1, 10));
            eff_w = (width == 0) ? 1 : 32'(width);
            // growing the line while copies are owed would replay unwritten columns
            if (pr_owed != 0 && eff_w > line_fill)
                width = pru_pkg::WIDTH_W'(line_fill);
            set_config(scale, width);
            if (seg == 4)
                hold_requests++;
            send_planned(SEG_ITEMS, NOISE_PCT);
            wait_idle();
        end

        repeat (8) @(posedge clk);
        if (expected_pixels.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, expected_pixels.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: pixel_replication_upscaler_top.f
+incdir+hw/rtl
hw/rtl/pru_pkg.sv
hw/rtl/pru_line_ram.sv
hw/rtl/pixel_replication_upscaler_top.sv
tb/tb.sv
